FILE: hdl/bhvs_pkg.sv
// Battery HV sequencing package: state, event and command codes, and shared types.
// No dependencies.
package bhvs_pkg;

   localparam int EVENT_W  = 5;
   localparam int STATE_W  = 4;
   localparam int PP_W     = 3;
   localparam int BC_W     = 2;
   localparam int REPORT_W = 2;

   // control states
   localparam logic [STATE_W-1:0] ST_SELF_CHECK  = 4'd0;
   localparam logic [STATE_W-1:0] ST_WAIT_UP     = 4'd1;
   localparam logic [STATE_W-1:0] ST_HV_DISABLED = 4'd2;
   localparam logic [STATE_W-1:0] ST_PRECHARGE   = 4'd3;
   localparam logic [STATE_W-1:0] ST_HV_ENABLED  = 4'd4;
   localparam logic [STATE_W-1:0] ST_DISCHARGE   = 4'd5;
   localparam logic [STATE_W-1:0] ST_CHARGING    = 4'd6;
   localparam logic [STATE_W-1:0] ST_BALANCING   = 4'd7;
   localparam logic [STATE_W-1:0] ST_FATAL       = 4'd8;
   localparam logic [STATE_W-1:0] ST_BRB_DISABLED = 4'd9;
   localparam logic [STATE_W-1:0] ST_BRB_ENABLED = 4'd10;

   // events
   localparam logic [EVENT_W-1:0] EV_INIT          = 5'd0;
   localparam logic [EVENT_W-1:0] EV_IMD_OK        = 5'd1;
   localparam logic [EVENT_W-1:0] EV_MON_READY     = 5'd2;
   localparam logic [EVENT_W-1:0] EV_BAL_START     = 5'd3;
   localparam logic [EVENT_W-1:0] EV_BAL_STOP      = 5'd4;
   localparam logic [EVENT_W-1:0] EV_NOTIFY_STOP   = 5'd5;
   localparam logic [EVENT_W-1:0] EV_NOTIFY_DONE   = 5'd6;
   localparam logic [EVENT_W-1:0] EV_ENTER_CHARGE  = 5'd7;
   localparam logic [EVENT_W-1:0] EV_CHG_BEGIN     = 5'd8;
   localparam logic [EVENT_W-1:0] EV_HV_SWITCH     = 5'd9;
   localparam logic [EVENT_W-1:0] EV_PRECHG_DONE   = 5'd10;
   localparam logic [EVENT_W-1:0] EV_DISCHG_DONE   = 5'd11;
   localparam logic [EVENT_W-1:0] EV_BRB_PRESSED   = 5'd12;
   localparam logic [EVENT_W-1:0] EV_BRB_RELEASED  = 5'd13;
   localparam logic [EVENT_W-1:0] EV_HV_TRIP       = 5'd14;
   localparam logic [EVENT_W-1:0] EV_PCDC_FAIL     = 5'd15;
   localparam logic [EVENT_W-1:0] EV_CHG_FAIL      = 5'd16;
   localparam logic [EVENT_W-1:0] EV_SET_CHG_MODE  = 5'd17;

   // power-path commands
   localparam logic [PP_W-1:0] PP_NONE        = 3'd0;
   localparam logic [PP_W-1:0] PP_PRE_CHARGER = 3'd1;
   localparam logic [PP_W-1:0] PP_PRE_MOTOR   = 3'd2;
   localparam logic [PP_W-1:0] PP_DISCHARGE   = 3'd3;
   localparam logic [PP_W-1:0] PP_STOP        = 3'd4;

   // battery commands
   localparam logic [BC_W-1:0] BC_NONE         = 2'd0;
   localparam logic [BC_W-1:0] BC_BAL_START    = 2'd1;
   localparam logic [BC_W-1:0] BC_STOP         = 2'd2;
   localparam logic [BC_W-1:0] BC_CHARGE_START = 2'd3;

   // reports
   localparam logic [REPORT_W-1:0] RPT_NONE      = 2'd0;
   localparam logic [REPORT_W-1:0] RPT_UNKNOWN   = 2'd1;
   localparam logic [REPORT_W-1:0] RPT_NOT_READY = 2'd2;
   localparam logic [REPORT_W-1:0] RPT_FATAL     = 2'd3;

   typedef struct packed {
      logic [STATE_W-1:0] control_state;
      logic               imd_ready;
      logic               monitor_ready;
      logic               chg_mode;
      logic               hv_power;
      logic               dcdc;
   } ctl_state_type;

   typedef struct packed {
      logic [STATE_W-1:0]  state_now;
      logic [PP_W-1:0]     power_path_command;
      logic [BC_W-1:0]     battery_command;
      logic                hv_power_on;
      logic                dcdc_on;
      logic                charger_setup;
      logic [REPORT_W-1:0] report;
      logic                not_ready_cause;
   } rsp_type;

endpackage

FILE: hdl/bhvs_if.sv
// Event request and result channel interfaces for the battery HV sequencer.
// Depends on bhvs_pkg.
interface bhvs_req_if import bhvs_pkg::*; ;
   logic               valid;
   logic               ready;
   logic [EVENT_W-1:0] event_req;
   logic               charge_mode_value;

   modport source (output valid, output event_req, output charge_mode_value, input ready);
   modport sink (input valid, input event_req, input charge_mode_value, output ready);
endinterface

interface bhvs_rsp_if import bhvs_pkg::*; ;
   logic                valid;
   logic                ready;
   logic [STATE_W-1:0]  state_now;
   logic [PP_W-1:0]     power_path_command;
   logic [BC_W-1:0]     battery_command;
   logic                hv_power_on;
   logic                dcdc_on;
   logic                charger_setup;
   logic [REPORT_W-1:0] report;
   logic                not_ready_cause;

   modport source (output valid, output state_now, output power_path_command,
                   output battery_command, output hv_power_on, output dcdc_on,
                   output charger_setup, output report, output not_ready_cause,
                   input ready);
   modport sink (input valid, input state_now, input power_path_command,
                 input battery_command, input hv_power_on, input dcdc_on,
                 input charger_setup, input report, input not_ready_cause,
                 output ready);
endinterface

FILE: hdl/bhvs_step.sv
// Transition decode: first-match row priority over (state, event), giving next state and result.
// Depends on bhvs_pkg.
module bhvs_step import bhvs_pkg::*; (
   input  ctl_state_type      cur,
   input  logic [EVENT_W-1:0] event_req,
   input  logic               charge_mode_value,
   output ctl_state_type      nxt,
   output rsp_type            res
);

   logic [STATE_W-1:0]  st;
   logic [PP_W-1:0]     pp;
   logic [BC_W-1:0]     bc;
   logic [PP_W-1:0]     pre_kind;
   logic                setup;
   logic [REPORT_W-1:0] rep;
   logic                cause;

   assign st       = cur.control_state;
   assign pre_kind = cur.chg_mode ? PP_PRE_CHARGER : PP_PRE_MOTOR;

   always_comb begin
      nxt   = cur;
      pp    = PP_NONE;
      bc    = BC_NONE;
      setup = 1'b0;
      rep   = RPT_NONE;
      cause = 1'b0;
      if (event_req == EV_SET_CHG_MODE) begin
         nxt.chg_mode = charge_mode_value;
      end else if (st == ST_SELF_CHECK && event_req == EV_INIT) begin
         nxt.chg_mode      = 1'b0;
         nxt.control_state = ST_WAIT_UP;
      end else if (st == ST_WAIT_UP &&
                   (event_req == EV_IMD_OK || event_req == EV_MON_READY)) begin
         if (event_req == EV_IMD_OK) begin
            nxt.imd_ready = 1'b1;
         end else begin
            nxt.monitor_ready = 1'b1;
         end
         if ((event_req == EV_IMD_OK || cur.imd_ready) &&
             (event_req == EV_MON_READY || cur.monitor_ready)) begin
            nxt.control_state = ST_HV_DISABLED;
         end
      end else if (st == ST_WAIT_UP) begin
         rep   = RPT_NOT_READY;
         cause = cur.imd_ready && !cur.monitor_ready;
      end else if (st == ST_HV_DISABLED && event_req == EV_BAL_START) begin
         bc                = BC_BAL_START;
         nxt.control_state = ST_BALANCING;
      end else if (st == ST_BALANCING && event_req == EV_BAL_STOP) begin
         bc = BC_STOP;
      end else if (st == ST_BALANCING &&
                   (event_req == EV_NOTIFY_STOP || event_req == EV_NOTIFY_DONE)) begin
         nxt.control_state = ST_HV_DISABLED;
      end else if (st == ST_HV_DISABLED && event_req == EV_ENTER_CHARGE) begin
         setup        = 1'b1;
         nxt.chg_mode = 1'b1;
      end else if (st == ST_HV_ENABLED && event_req == EV_CHG_BEGIN) begin
         if (cur.chg_mode) begin
            bc                = BC_CHARGE_START;
            nxt.control_state = ST_CHARGING;
         end
      end else if (st == ST_CHARGING && event_req == EV_NOTIFY_STOP) begin
         bc = BC_STOP;
      end else if (st == ST_CHARGING && event_req == EV_NOTIFY_DONE) begin
         nxt.control_state = ST_HV_ENABLED;
      end else if (event_req == EV_NOTIFY_STOP) begin
         // stop notice elsewhere: no change
      end else if (st == ST_HV_DISABLED && event_req == EV_HV_SWITCH) begin
         pp                = pre_kind;
         nxt.control_state = ST_PRECHARGE;
      end else if (st == ST_PRECHARGE && event_req == EV_PRECHG_DONE) begin
         nxt.hv_power      = 1'b1;
         nxt.dcdc          = 1'b1;
         nxt.control_state = ST_HV_ENABLED;
      end else if (st == ST_HV_ENABLED && event_req == EV_HV_SWITCH) begin
         pp                = PP_DISCHARGE;
         nxt.control_state = ST_DISCHARGE;
      end else if (st == ST_PRECHARGE && event_req == EV_HV_SWITCH) begin
         pp                = PP_STOP;
         nxt.control_state = ST_HV_DISABLED;
      end else if (st == ST_DISCHARGE && event_req == EV_DISCHG_DONE) begin
         nxt.hv_power      = 1'b0;
         nxt.dcdc          = 1'b0;
         nxt.control_state = ST_HV_DISABLED;
      end else if (st == ST_DISCHARGE && event_req == EV_HV_SWITCH) begin
         // toggle while discharging: no change
      end else if (event_req == EV_ENTER_CHARGE) begin
         // charge mode request outside hv disabled: ignored
      end else if (event_req == EV_BRB_PRESSED) begin
         nxt.hv_power = 1'b0;
         nxt.dcdc     = 1'b0;
         unique case (st) inside
            ST_HV_DISABLED, ST_DISCHARGE: begin
               nxt.control_state = ST_BRB_DISABLED;
            end
            ST_HV_ENABLED: begin
               pp                = PP_DISCHARGE;
               nxt.control_state = ST_BRB_ENABLED;
            end
            ST_PRECHARGE: begin
               pp                = PP_STOP;
               nxt.control_state = ST_BRB_ENABLED;
            end
            default: begin
               pp                = PP_DISCHARGE;
               nxt.control_state = ST_BRB_DISABLED;
            end
         endcase
      end else if (st == ST_BRB_DISABLED && event_req == EV_BRB_RELEASED) begin
         nxt.control_state = ST_HV_DISABLED;
      end else if (st == ST_BRB_ENABLED && event_req == EV_BRB_RELEASED) begin
         pp                = pre_kind;
         nxt.control_state = ST_PRECHARGE;
      end else if (st == ST_BRB_ENABLED && event_req == EV_DISCHG_DONE) begin
         nxt.hv_power = 1'b0;
         nxt.dcdc     = 1'b0;
      end else if (st == ST_FATAL) begin
         // already fatal: no change
      end else if (event_req == EV_HV_TRIP || event_req == EV_PCDC_FAIL ||
                   event_req == EV_CHG_FAIL) begin
         rep               = RPT_FATAL;
         nxt.hv_power      = 1'b0;
         nxt.dcdc          = 1'b0;
         nxt.control_state = ST_FATAL;
         unique case (st) inside
            ST_HV_DISABLED, ST_DISCHARGE: begin
               pp = PP_NONE;
            end
            ST_PRECHARGE: begin
               pp = (event_req != EV_PCDC_FAIL) ? PP_STOP : PP_NONE;
            end
            default: begin
               pp = PP_DISCHARGE;
            end
         endcase
      end else begin
         rep = RPT_UNKNOWN;
      end
   end

   assign res.state_now          = nxt.control_state;
   assign res.power_path_command = pp;
   assign res.battery_command    = bc;
   assign res.hv_power_on        = nxt.hv_power;
   assign res.dcdc_on            = nxt.dcdc;
   assign res.charger_setup      = setup;
   assign res.report             = rep;
   assign res.not_ready_cause    = cause;

endmodule

FILE: hdl/battery_hv_sequencing_fsm.sv
// Channel     | Dir | Payload
// ------------+-----+---------------------------------------------------------------
// req_ch      | in  | event_req[4:0], charge_mode_value
// rsp_ch      | out | state_now, power_path_command, battery_command, hv_power_on,
//             |     | dcdc_on, charger_setup, report, not_ready_cause
//
// One transaction per cycle while the result side does not stall: an event is held in the
// input register, is decoded against the control state, and its result lands in the
// result register.
// Reset (synchronous) returns the control state to self check with all flags and levels off.
// A stalled result holds the decode stage; the input register still refills as it drains.
// Depends on bhvs_pkg, bhvs_if and bhvs_step.
module battery_hv_sequencing_fsm import bhvs_pkg::*; (
   input logic        clock,
   input logic        reset,
   bhvs_req_if.sink   req_ch,
   bhvs_rsp_if.source rsp_ch
);

   logic               in_valid_ff;
   logic               in_valid_in;
   logic [EVENT_W-1:0] event_ff;
   logic               cmv_ff;
   logic               out_valid_ff;
   logic               out_valid_in;
   rsp_type            rsp_ff;
   ctl_state_type      ctl_ff;
   ctl_state_type      ctl_next;
   rsp_type            step_res;
   logic               advance;
   logic               req_take;

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !in_valid_ff || advance;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   bhvs_step u_step (
      .cur               (ctl_ff),
      .event_req         (event_ff),
      .charge_mode_value (cmv_ff),
      .nxt               (ctl_next),
      .res               (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ctl_ff       <= '{control_state: ST_SELF_CHECK, default: 1'b0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            ctl_ff <= ctl_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         event_ff <= req_ch.event_req;
         cmv_ff   <= req_ch.charge_mode_value;
      end
      if (advance) begin
         rsp_ff <= step_res;
      end
   end

   assign rsp_ch.valid              = out_valid_ff;
   assign rsp_ch.state_now          = rsp_ff.state_now;
   assign rsp_ch.power_path_command = rsp_ff.power_path_command;
   assign rsp_ch.battery_command    = rsp_ff.battery_command;
   assign rsp_ch.hv_power_on        = rsp_ff.hv_power_on;
   assign rsp_ch.dcdc_on            = rsp_ff.dcdc_on;
   assign rsp_ch.charger_setup      = rsp_ff.charger_setup;
   assign rsp_ch.report             = rsp_ff.report;
   assign rsp_ch.not_ready_cause    = rsp_ff.not_ready_cause;

endmodule

FILE: verif/battery_hv_sequencing_fsm_tb.sv
`timescale 1ns / 1ps
// Testbench for battery_hv_sequencing_fsm: directed and random event streams checked against
// a cycle-free model of the HV control machine. Depends on bhvs_pkg, bhvs_if and the design.
module battery_hv_sequencing_fsm_tb;
   import bhvs_pkg::*;

   localparam int RANDOM_ITEMS  = 560;
   localparam int LONG_STALL    = 150;
   localparam int WATCHDOG_MAX  = 1000;
   localparam int DRAIN_CYCLES  = 8;

   logic clock;
   logic reset;

   bhvs_req_if req_ch ();
   bhvs_rsp_if rsp_ch ();

   battery_hv_sequencing_fsm u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   ctl_state_type hv_model;
   rsp_type       predicted_outcomes [$];
   int            errors = 0;
   int            req_idle_pct = 0;
   int            rsp_idle_pct = 0;
   int            stall_seq = 0;
   int            quiet_cycles = 0;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // model of the control machine, first matching row wins
   function automatic rsp_type advance_hv_machine(logic [EVENT_W-1:0] ev, logic cmv);
      rsp_type            r;
      logic [STATE_W-1:0] st;
      logic [STATE_W-1:0] nxt;
      logic [PP_W-1:0]    pre_kind;
      r = '0;
      st = hv_model.control_state;
      nxt = st;
      pre_kind = hv_model.chg_mode ? PP_PRE_CHARGER : PP_PRE_MOTOR;
      r.power_path_command = PP_NONE;
      r.battery_command = BC_NONE;
      r.report = RPT_NONE;
      if (ev == EV_SET_CHG_MODE) begin
         hv_model.chg_mode = cmv;
      end else if (st == ST_SELF_CHECK && ev == EV_INIT) begin
         hv_model.chg_mode = 1'b0;
         nxt = ST_WAIT_UP;
      end else if (st == ST_WAIT_UP && (ev == EV_IMD_OK || ev == EV_MON_READY)) begin
         if (ev == EV_IMD_OK) hv_model.imd_ready = 1'b1;
         else hv_model.monitor_ready = 1'b1;
         nxt = (hv_model.imd_ready && hv_model.monitor_ready) ? ST_HV_DISABLED : ST_WAIT_UP;
      end else if (st == ST_WAIT_UP) begin
         r.report = RPT_NOT_READY;
         r.not_ready_cause = hv_model.imd_ready && !hv_model.monitor_ready;
      end else if (st == ST_HV_DISABLED && ev == EV_BAL_START) begin
         r.battery_command = BC_BAL_START;
         nxt = ST_BALANCING;
      end else if (st == ST_BALANCING && ev == EV_BAL_STOP) begin
         r.battery_command = BC_STOP;
      end else if (st == ST_BALANCING && (ev == EV_NOTIFY_STOP || ev == EV_NOTIFY_DONE)) begin
         nxt = ST_HV_DISABLED;
      end else if (st == ST_HV_DISABLED && ev == EV_ENTER_CHARGE) begin
         r.charger_setup = 1'b1;
         hv_model.chg_mode = 1'b1;
      end else if (st == ST_HV_ENABLED && ev == EV_CHG_BEGIN) begin
         if (hv_model.chg_mode) begin
            r.battery_command = BC_CHARGE_START;
            nxt = ST_CHARGING;
         end
      end else if (st == ST_CHARGING && ev == EV_NOTIFY_STOP) begin
         r.battery_command = BC_STOP;
      end else if (st == ST_CHARGING && ev == EV_NOTIFY_DONE) begin
         nxt = ST_HV_ENABLED;
      end else if (ev == EV_NOTIFY_STOP) begin
      end else if (st == ST_HV_DISABLED && ev == EV_HV_SWITCH) begin
         r.power_path_command = pre_kind;
         nxt = ST_PRECHARGE;
      end else if (st == ST_PRECHARGE && ev == EV_PRECHG_DONE) begin
         hv_model.hv_power = 1'b1;
         hv_model.dcdc = 1'b1;
         nxt = ST_HV_ENABLED;
      end else if (st == ST_HV_ENABLED && ev == EV_HV_SWITCH) begin
         r.power_path_command = PP_DISCHARGE;
         nxt = ST_DISCHARGE;
      end else if (st == ST_PRECHARGE && ev == EV_HV_SWITCH) begin
         r.power_path_command = PP_STOP;
         nxt = ST_HV_DISABLED;
      end else if (st == ST_DISCHARGE && ev == EV_DISCHG_DONE) begin
         hv_model.hv_power = 1'b0;
         hv_model.dcdc = 1'b0;
         nxt = ST_HV_DISABLED;
      end else if (st == ST_DISCHARGE && ev == EV_HV_SWITCH) begin
      end else if (ev == EV_ENTER_CHARGE) begin
      end else if (ev == EV_BRB_PRESSED) begin
         hv_model.hv_power = 1'b0;
         hv_model.dcdc = 1'b0;
         if (st == ST_HV_DISABLED) begin
            nxt = ST_BRB_DISABLED;
         end else if (st == ST_HV_ENABLED) begin
            r.power_path_command = PP_DISCHARGE;
            nxt = ST_BRB_ENABLED;
         end else if (st == ST_PRECHARGE) begin
            r.power_path_command = PP_STOP;
            nxt = ST_BRB_ENABLED;
         end else if (st == ST_DISCHARGE) begin
            nxt = ST_BRB_DISABLED;
         end else begin
            r.power_path_command = PP_DISCHARGE;
            nxt = ST_BRB_DISABLED;
         end
      end else if (st == ST_BRB_DISABLED && ev == EV_BRB_RELEASED) begin
         nxt = ST_HV_DISABLED;
      end else if (st == ST_BRB_ENABLED && ev == EV_BRB_RELEASED) begin
         r.power_path_command = pre_kind;
         nxt = ST_PRECHARGE;
      end else if (st == ST_BRB_ENABLED && ev == EV_DISCHG_DONE) begin
         hv_model.hv_power = 1'b0;
         hv_model.dcdc = 1'b0;
      end else if (st == ST_FATAL) begin
      end else if (ev == EV_HV_TRIP || ev == EV_PCDC_FAIL || ev == EV_CHG_FAIL) begin
         r.report = RPT_FATAL;
         hv_model.hv_power = 1'b0;
         hv_model.dcdc = 1'b0;
         if (st == ST_HV_DISABLED || st == ST_DISCHARGE)
            r.power_path_command = PP_NONE;
         else if (st == ST_PRECHARGE)
            r.power_path_command = (ev != EV_PCDC_FAIL) ? PP_STOP : PP_NONE;
         else
            r.power_path_command = PP_DISCHARGE;
         nxt = ST_FATAL;
      end else begin
         r.report = RPT_UNKNOWN;
      end
      hv_model.control_state = nxt;
      r.state_now = nxt;
      r.hv_power_on = hv_model.hv_power;
      r.dcdc_on = hv_model.dcdc;
      return r;
   endfunction

   // mostly events that move the machine along from where it stands; faults excluded
   function automatic logic [EVENT_W-1:0] pick_event();
      logic [EVENT_W-1:0] opts [$];
      logic [EVENT_W-1:0] ev;
      int                 roll;
      roll = $urandom_range(99);
      if (roll < 8) return EV_SET_CHG_MODE;
      if (roll < 30) begin
         ev = 5'($urandom_range(31));
         if (ev >= EV_HV_TRIP && ev <= EV_CHG_FAIL) ev = ev + 5'd8;
         return ev;
      end
      case (hv_model.control_state)
         ST_SELF_CHECK:   opts = '{EV_INIT};
         ST_WAIT_UP:      opts = '{EV_IMD_OK, EV_MON_READY};
         ST_HV_DISABLED:  opts = '{EV_BAL_START, EV_ENTER_CHARGE, EV_HV_SWITCH, EV_HV_SWITCH,
                                   EV_BRB_PRESSED};
         ST_BALANCING:    opts = '{EV_BAL_STOP, EV_NOTIFY_STOP, EV_NOTIFY_DONE, EV_BRB_PRESSED};
         ST_PRECHARGE:    opts = '{EV_PRECHG_DONE, EV_PRECHG_DONE, EV_HV_SWITCH, EV_BRB_PRESSED};
         ST_HV_ENABLED:   opts = '{EV_CHG_BEGIN, EV_CHG_BEGIN, EV_HV_SWITCH,
                                   EV_BRB_PRESSED, EV_NOTIFY_STOP};
         ST_DISCHARGE:    opts = '{EV_DISCHG_DONE, EV_DISCHG_DONE, EV_HV_SWITCH, EV_BRB_PRESSED};
         ST_CHARGING:     opts = '{EV_NOTIFY_STOP, EV_NOTIFY_DONE, EV_BRB_PRESSED};
         ST_BRB_ENABLED:  opts = '{EV_BRB_RELEASED, EV_DISCHG_DONE, EV_BRB_PRESSED};
         default:         opts = '{EV_BRB_RELEASED};
      endcase
      return opts[$urandom_range(opts.size() - 1)];
   endfunction

   task automatic send_event(input logic [EVENT_W-1:0] ev, input logic cmv);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.event_req <= ev;
      req_ch.charge_mode_value <= cmv;
      do @(posedge clock); while (!req_ch.ready);
      predicted_outcomes.push_back(advance_hv_machine(ev, cmv));
   endtask

   // sender pauses until every predicted result has come back
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (predicted_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic test_wakeup();
      send_event(5'd31, 1'b0);
      send_event(EV_SET_CHG_MODE, 1'b1);
      send_event(EV_BRB_RELEASED, 1'b1);
      send_event(EV_INIT, 1'b0);
      send_event(5'd18, 1'b1);
      send_event(EV_IMD_OK, 1'b0);
      send_event(EV_HV_SWITCH, 1'b0);
      send_event(EV_MON_READY, 1'b0);
      drain_results();
   endtask

   task automatic test_power_sequences();
      send_event(EV_HV_SWITCH, 1'b0);
      send_event(EV_PRECHG_DONE, 1'b0);
      send_event(EV_CHG_BEGIN, 1'b1);
      send_event(EV_HV_SWITCH, 1'b0);
      send_event(EV_HV_SWITCH, 1'b0);
      send_event(EV_DISCHG_DONE, 1'b0);
      send_event(EV_ENTER_CHARGE, 1'b0);
      send_event(EV_HV_SWITCH, 1'b0);
      send_event(EV_BRB_PRESSED, 1'b0);
      send_event(EV_BRB_RELEASED, 1'b0);
      send_event(EV_PRECHG_DONE, 1'b0);
      send_event(EV_CHG_BEGIN, 1'b0);
      send_event(EV_NOTIFY_STOP, 1'b0);
      send_event(EV_NOTIFY_DONE, 1'b0);
      send_event(EV_BRB_PRESSED, 1'b0);
      send_event(EV_DISCHG_DONE, 1'b0);
      send_event(EV_SET_CHG_MODE, 1'b0);
      drain_results();
   endtask

   task automatic test_random_events(input int req_pct, input int rsp_pct);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      repeat (RANDOM_ITEMS) send_event(pick_event(), 1'($urandom_range(1)));
      drain_results();
   endtask

   // result side held off while the sender keeps offering
   task automatic test_result_backpressure();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      stall_seq <= stall_seq + 1;
      repeat (40) send_event(pick_event(), 1'($urandom_range(1)));
      drain_results();
   endtask

   // fatal is left only on a BRB press, so it comes last: wander, fault, then poke the machine
   task automatic test_fatal_fault();
      req_idle_pct = 10;
      rsp_idle_pct = 10;
      repeat ($urandom_range(15)) send_event(pick_event(), 1'($urandom_range(1)));
      send_event(5'($urandom_range(EV_HV_TRIP, EV_CHG_FAIL)), 1'($urandom_range(1)));
      repeat (8) send_event(5'($urandom_range(31)), 1'($urandom_range(1)));
      drain_results();
   endtask

   always @(posedge clock) begin
      int stall_left;
      int stall_seen;
      if (stall_seq != stall_seen) begin
         stall_seen = stall_seq;
         stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   function automatic void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (predicted_outcomes.size() == 0) begin
            $error("unexpected transaction: state_now %0d", rsp_ch.state_now);
            errors++;
         end else begin
            exp_r = predicted_outcomes.pop_front();
            compare_field("state_now", exp_r.state_now, rsp_ch.state_now);
            compare_field("power_path_command", exp_r.power_path_command,
                          rsp_ch.power_path_command);
            compare_field("battery_command", exp_r.battery_command, rsp_ch.battery_command);
            compare_field("hv_power_on", exp_r.hv_power_on, rsp_ch.hv_power_on);
            compare_field("dcdc_on", exp_r.dcdc_on, rsp_ch.dcdc_on);
            compare_field("charger_setup", exp_r.charger_setup, rsp_ch.charger_setup);
            compare_field("report", exp_r.report, rsp_ch.report);
            compare_field("not_ready_cause", exp_r.not_ready_cause, rsp_ch.not_ready_cause);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < WATCHDOG_MAX) @(posedge clock);
      $display("battery_hv_sequencing_fsm verification failed");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.event_req <= EV_INIT;
      req_ch.charge_mode_value <= 1'b0;
      hv_model = '0;
      hv_model.control_state = ST_SELF_CHECK;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_wakeup();
      test_power_sequences();
      test_random_events(21, 49);
      test_random_events(49, 21);
      test_random_events(0, 0);
      test_result_backpressure();
      test_fatal_fault();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (predicted_outcomes.size() != 0) begin
         $error("%0d results never arrived", predicted_outcomes.size());
         errors++;
      end
      if (errors == 0)
         $display("battery_hv_sequencing_fsm verification clean");
      else
         $display("battery_hv_sequencing_fsm verification failed");
      $finish;
   end

endmodule

FILE: files.f
hdl/bhvs_pkg.sv
hdl/bhvs_if.sv
hdl/bhvs_step.sv
hdl/battery_hv_sequencing_fsm.sv
verif/battery_hv_sequencing_fsm_tb.sv
